// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent holds in this cycle -> consequent holds in the same cycle.
`define CSW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent holds in this cycle -> consequent holds in the next cycle.
`define CSW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CSW_ASSERT_IMP(lbl, ante, cons)
`define CSW_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/csw_pkg.sv =====
// ----------------------------------------------------------------------------
// csw_pkg
// Shared types and codes of the counting semaphore with timed waiters.
// ----------------------------------------------------------------------------
package csw_pkg;

    // request modes
    localparam logic [1:0] MODE_WAIT   = 2'd0;
    localparam logic [1:0] MODE_SIGNAL = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    // response kinds
    localparam logic [2:0] KIND_GRANTED   = 3'd0;
    localparam logic [2:0] KIND_BLOCKED   = 3'd1;
    localparam logic [2:0] KIND_REL_SIG   = 3'd2;
    localparam logic [2:0] KIND_REL_TMO   = 3'd3;
    localparam logic [2:0] KIND_SIG_DONE  = 3'd4;
    localparam logic [2:0] KIND_TICK_DONE = 3'd5;
    localparam logic [2:0] KIND_SIG_ERR   = 3'd6;
    localparam logic [2:0] KIND_Q_FULL    = 3'd7;

    // one queued waiter
    typedef struct packed {
        logic [7:0]  thread;
        logic [15:0] ticks;
        logic        unlimited;
    } entry_t;

    // queue control from the sequencer
    typedef struct packed {
        logic   shift;      // every cell takes its right neighbor (the tail keeps its own)
        logic   load;       // the addressed cell takes load_data
        entry_t load_data;
    } queue_ctrl_t;

    // saturating add to the 16-bit count
    function automatic logic signed [15:0] sat_add(logic signed [15:0] a,
                                                   logic signed [8:0] b);
        logic [16:0] s;
        s = {a[15], a} + {{8{b[8]}}, b};
        if (s[16] != s[15])
            sat_add = s[16] ? 16'sh8000 : 16'sh7FFF;
        else
            sat_add = s[15:0];
    endfunction

endpackage

// ===== rtl/csw_if.sv =====
// ----------------------------------------------------------------------------
// csw_req_if / csw_rsp_if
// Valid/ready channels for semaphore requests and responses.
// ----------------------------------------------------------------------------
interface csw_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [7:0]        thread_id;
    logic [15:0]       max_wait;
    logic signed [7:0] signal_count;

    modport source (output valid, mode, thread_id, max_wait, signal_count, input ready);
    modport sink   (input valid, mode, thread_id, max_wait, signal_count, output ready);
endinterface

interface csw_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [7:0]         released_thread;
    logic signed [7:0]  released_total;
    logic signed [15:0] count_now;
    logic               last;

    modport source (output valid, kind, released_thread, released_total, count_now, last,
                    input ready);
    modport sink   (input valid, kind, released_thread, released_total, count_now, last,
                    output ready);
endinterface

// ===== rtl/csw_cell.sv =====
// ----------------------------------------------------------------------------
// csw_cell
// One queue slot: holds a waiter, takes its right neighbor on shift.
// ----------------------------------------------------------------------------
module csw_cell (
    input  logic            clk,
    input  logic            shift,
    input  logic            load,
    input  csw_pkg::entry_t load_data,
    input  csw_pkg::entry_t right,
    output csw_pkg::entry_t entry
);

    csw_pkg::entry_t entry_reg;
    csw_pkg::entry_t entry_next;

    // load wins over shift (rotate-back writes the vacated tail slot)
    always_comb
    begin
        if (load)
            entry_next = load_data;
        else if (shift)
            entry_next = right;
        else
            entry_next = entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/csw_queue.sv =====
// ----------------------------------------------------------------------------
// csw_queue
// Shift chain of waiter cells; slot 0 is the head of the FIFO.
// ----------------------------------------------------------------------------
module csw_queue #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                 clk,
    input  csw_pkg::queue_ctrl_t ctrl,
    input  logic [IDX_W-1:0]     wr_idx,
    output csw_pkg::entry_t      head
);

    csw_pkg::entry_t cells [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        csw_pkg::entry_t right;

        if (i == DEPTH - 1)
        begin : g_tail
            assign right = cells[i];
        end
        else
        begin : g_mid
            assign right = cells[i+1];
        end

        csw_cell u_cell (
            .clk       (clk),
            .shift     (ctrl.shift),
            .load      (ctrl.load && (wr_idx == IDX_W'(i))),
            .load_data (ctrl.load_data),
            .right     (right),
            .entry     (cells[i])
        );
    end

    assign head = cells[0];

endmodule

// ===== rtl/counting_semaphore_timed_waiters.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_timed_waiters
// Counting semaphore with a FIFO of waiting threads, each with a tick timeout.
// ----------------------------------------------------------------------------
// One request is handled at a time. A wait, a negative signal or an unused mode
// gives one response. A signal of n pops up to n waiters (one for a signal of
// 0) at one response per cycle while the receiver takes them, then the done
// response. A timer tick walks every queued waiter through the head cell, one
// per cycle unless a release waits on the receiver: a limited waiter is counted
// down and either released (one response) or rotated back to the tail. Each
// response waits in an output register, so the next request is taken as soon
// as the last response of the current one is loaded there. The count saturates
// at -32768..32767; a write to the configuration register loads the count and
// leaves the queue as it is.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module counting_semaphore_timed_waiters #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,
    csw_req_if.sink     req,
    csw_rsp_if.source   rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ONE,   // single-response requests
        S_SIG,   // signal: pop waiters, then done
        S_TICK   // tick: walk the queue, then done
    } state_t;

    state_t             state_reg, state_next;

    // latched request
    logic [1:0]         mode_reg, mode_next;
    logic [7:0]         thread_reg, thread_next;
    logic [15:0]        wait_reg, wait_next;
    logic signed [7:0]  sc_reg, sc_next;

    // semaphore state
    logic signed [15:0] count_reg, count_next;
    logic [CNT_W-1:0]   used_reg, used_next;

    // sequencing
    logic [7:0]         budget_reg, budget_next;   // waiters a signal may free
    logic [7:0]         freed_reg, freed_next;
    logic               zero_sig_reg, zero_sig_next;
    logic [CNT_W-1:0]   step_reg, step_next;       // tick entries still to visit

    // response register
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_kind_reg, out_kind_next;
    logic [7:0]         out_thread_reg, out_thread_next;
    logic signed [7:0]  out_total_reg, out_total_next;
    logic signed [15:0] out_count_reg, out_count_next;
    logic               out_last_reg, out_last_next;

    csw_pkg::queue_ctrl_t q_ctrl;
    logic [IDX_W-1:0]     q_idx;
    csw_pkg::entry_t      head;

    logic can_emit;
    logic req_take;
    logic head_expired;

    assign req.ready = (state_reg == S_IDLE);
    assign req_take  = req.valid && req.ready;
    assign can_emit  = !out_valid_reg || rsp.ready;

    // a limited waiter with one tick left (or none) leaves on this tick
    assign head_expired = !head.unlimited && (head.ticks <= 16'd1);

    csw_queue #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_queue (
        .clk    (clk),
        .ctrl   (q_ctrl),
        .wr_idx (q_idx),
        .head   (head)
    );

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        thread_next     = thread_reg;
        wait_next       = wait_reg;
        sc_next         = sc_reg;
        count_next      = count_reg;
        used_next       = used_reg;
        budget_next     = budget_reg;
        freed_next      = freed_reg;
        zero_sig_next   = zero_sig_reg;
        step_next       = step_reg;

        out_valid_next  = out_valid_reg && !rsp.ready;
        out_kind_next   = out_kind_reg;
        out_thread_next = out_thread_reg;
        out_total_next  = out_total_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        q_ctrl.shift     = 1'b0;
        q_ctrl.load      = 1'b0;
        q_ctrl.load_data = head;
        q_idx            = used_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    mode_next   = req.mode;
                    thread_next = req.thread_id;
                    wait_next   = req.max_wait;
                    sc_next     = req.signal_count;
                    freed_next  = 8'd0;
                    if (req.mode == csw_pkg::MODE_SIGNAL && !req.signal_count[7])
                    begin
                        if (req.signal_count == 8'sd0)
                        begin
                            // signal of 0: increment first, free one if count was negative
                            count_next    = csw_pkg::sat_add(count_reg, 9'sd1);
                            budget_next   = (count_reg[15] && used_reg != '0) ? 8'd1 : 8'd0;
                            zero_sig_next = 1'b1;
                        end
                        else
                        begin
                            budget_next   = req.signal_count;
                            zero_sig_next = 1'b0;
                        end
                        state_next = S_SIG;
                    end
                    else if (req.mode == csw_pkg::MODE_TICK)
                    begin
                        step_next  = used_reg;
                        state_next = S_TICK;
                    end
                    else
                    begin
                        state_next = S_ONE;
                    end
                end
            end

            S_ONE:
            begin
                if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_thread_next = 8'd0;
                    out_total_next  = 8'sd0;
                    case (mode_reg)
                        csw_pkg::MODE_WAIT:
                        begin
                            out_thread_next = thread_reg;
                            if (!count_reg[15] && count_reg != 16'sd0)
                            begin
                                count_next    = count_reg - 16'sd1;
                                out_kind_next = csw_pkg::KIND_GRANTED;
                            end
                            else if (used_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                out_kind_next = csw_pkg::KIND_Q_FULL;
                            end
                            else
                            begin
                                count_next = csw_pkg::sat_add(count_reg, -9'sd1);
                                q_ctrl.load                = 1'b1;
                                q_ctrl.load_data.thread    = thread_reg;
                                q_ctrl.load_data.ticks     = wait_reg;
                                q_ctrl.load_data.unlimited = (wait_reg == 16'd0);
                                used_next     = used_reg + 1'b1;
                                out_kind_next = csw_pkg::KIND_BLOCKED;
                            end
                        end
                        csw_pkg::MODE_SIGNAL:
                        begin
                            out_kind_next  = csw_pkg::KIND_SIG_ERR;
                            out_total_next = sc_reg;
                        end
                        default:
                        begin
                            out_kind_next = csw_pkg::KIND_TICK_DONE;
                        end
                    endcase
                    out_count_next = count_next;
                    state_next     = S_IDLE;
                end
            end

            S_SIG:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = 8'sd0;
                    if (used_reg != '0 && freed_reg < budget_reg)
                    begin
                        q_ctrl.shift    = 1'b1;
                        used_next       = used_reg - 1'b1;
                        freed_next      = freed_reg + 8'd1;
                        out_kind_next   = csw_pkg::KIND_REL_SIG;
                        out_thread_next = head.thread;
                        out_count_next  = count_reg;
                        out_last_next   = 1'b0;
                    end
                    else
                    begin
                        // sc_reg is 0 for a signal of 0: its increment is already in
                        count_next      = csw_pkg::sat_add(count_reg, {sc_reg[7], sc_reg});
                        out_kind_next   = csw_pkg::KIND_SIG_DONE;
                        out_thread_next = 8'd0;
                        out_total_next  = zero_sig_reg ? 8'sd0 : freed_reg;
                        out_count_next  = count_next;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end

            S_TICK:
            begin
                if (step_reg != '0)
                begin
                    if (head_expired)
                    begin
                        if (can_emit)
                        begin
                            q_ctrl.shift    = 1'b1;
                            used_next       = used_reg - 1'b1;
                            step_next       = step_reg - 1'b1;
                            count_next      = csw_pkg::sat_add(count_reg, 9'sd1);
                            out_valid_next  = 1'b1;
                            out_kind_next   = csw_pkg::KIND_REL_TMO;
                            out_thread_next = head.thread;
                            out_total_next  = 8'sd0;
                            out_count_next  = count_next;
                            out_last_next   = 1'b0;
                        end
                    end
                    else
                    begin
                        // survivor: pop the head and put it back at the tail
                        q_ctrl.shift = 1'b1;
                        q_ctrl.load  = 1'b1;
                        q_idx        = IDX_W'(used_reg - 1'b1);
                        if (!head.unlimited)
                            q_ctrl.load_data.ticks = head.ticks - 16'd1;
                        step_next = step_reg - 1'b1;
                    end
                end
                else if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = csw_pkg::KIND_TICK_DONE;
                    out_thread_next = 8'd0;
                    out_total_next  = 8'sd0;
                    out_count_next  = count_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write loads the count (the user must write only while idle; the block does not enforce it)
        if (cfg_wr_en)
            count_next = {1'b0, cfg_wr_data};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= csw_pkg::MODE_WAIT;
            thread_reg     <= 8'd0;
            wait_reg       <= 16'd0;
            sc_reg         <= 8'sd0;
            count_reg      <= 16'sd0;
            used_reg       <= '0;
            step_reg       <= '0;
            freed_reg      <= 8'd0;
            budget_reg     <= 8'd0;
            zero_sig_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= csw_pkg::KIND_GRANTED;
            out_thread_reg <= 8'd0;
            out_total_reg  <= 8'sd0;
            out_count_reg  <= 16'sd0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            thread_reg     <= thread_next;
            wait_reg       <= wait_next;
            sc_reg         <= sc_next;
            count_reg      <= count_next;
            used_reg       <= used_next;
            step_reg       <= step_next;
            freed_reg      <= freed_next;
            budget_reg     <= budget_next;
            zero_sig_reg   <= zero_sig_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_thread_reg <= out_thread_next;
            out_total_reg  <= out_total_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.kind            = out_kind_reg;
    assign rsp.released_thread = out_thread_reg;
    assign rsp.released_total  = out_total_reg;
    assign rsp.count_now       = out_count_reg;
    assign rsp.last            = out_last_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `CSW_ASSERT_IMP(a_used_in_range, 1'b1, used_reg <= CNT_W'(QUEUE_DEPTH))
    `CSW_ASSERT_IMP(a_tick_walk_bound, state_reg == S_TICK, step_reg <= used_reg)
    `CSW_ASSERT_NXT(a_one_at_a_time, req_take, !req.ready)
    `CSW_ASSERT_NXT(a_cfg_loads_count, cfg_wr_en, count_reg == {1'b0, $past(cfg_wr_data)})

endmodule

// ===== verif/tb_counting_semaphore_timed_waiters.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_counting_semaphore_timed_waiters
// Self-checking bench for the counting semaphore with timed waiters. A short
// table of directed requests runs first, then about 340 shaped random requests
// in phases with various initial counts. Every response is checked field by field
// against a behavioral predictor of the count and queue, or its typed-in response.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_timed_waiters;

    // mode 3 is not decoded by the block; it answers with a plain tick-done
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int DEPTH           = 16;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 49;
    localparam int LIMIT           = 1_000_000;
    // a tick walks the whole queue; the settle time follows the depth, plus slack
    localparam int SETTLE          = DEPTH + 8;

    // one request as presented on the request channel
    typedef struct packed {
        logic [1:0]        mode;
        logic [7:0]        thread;
        logic [15:0]       max_wait;
        logic signed [7:0] sig;
    } sem_req_t;

    // one response as seen on the response channel
    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         thread;
        logic signed [7:0]  total;
        logic signed [15:0] count;
        logic               last;
    } sem_rsp_t;

    // row of the directed table: either a register write or a request,
    // optionally with its single response typed in
    typedef struct {
        bit          cfg;
        logic [14:0] cfg_val;
        sem_req_t    req;
        bit          typed;
        sem_rsp_t    want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;

    csw_req_if req_ch();
    csw_rsp_if rsp_ch();

    counting_semaphore_timed_waiters u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: the count and the FIFO of waiters
    // ------------------------------------------------------------------
    logic signed [15:0] sem_count;
    csw_pkg::entry_t    waiters[$];
    sem_rsp_t           step_responses[$];  // responses of the request just taken
    sem_rsp_t           due_responses[$];   // responses still to arrive, oldest first
    plan_row_t          plan[$];

    int errors = 0;
    int cycles = 0;
    int src_odds = 3;   // 1-in-N chance of a sender gap, 0 = never
    int sink_odds = 3;  // 1-in-N chance of a receiver stall, 0 = never
    int stall_left = 0;

    int          phase_wait_pct[PHASES]  = '{70, 55, 60, 80, 50, 55, 65};
    int          phase_src_odds[PHASES]  = '{3, 4, 0, 2, 6, 3, 0};
    int          phase_sink_odds[PHASES] = '{3, 2, 0, 4, 3, 5, 0};
    logic [14:0] phase_cfg[PHASES]       = '{15'd0, 15'd3, 15'h7FFF, 15'd0, 15'd1,
                                             15'd0, 15'd0};

    // every count change clamps to the 16-bit signed range
    function automatic logic signed [15:0] clamp_count(logic signed [15:0] c, int d);
        int s;
        s = int'(c) + d;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return 16'(s);
    endfunction

    function automatic void note(logic [2:0] k, logic [7:0] t, logic signed [7:0] tot,
                                 logic l);
        step_responses.push_back('{kind: k, thread: t, total: tot, count: sem_count,
                                   last: l});
    endfunction

    // Works out the responses of one request and advances the predictor.
    function automatic void semaphore_step(sem_req_t r);
        int              freed;
        bit              was_neg;
        csw_pkg::entry_t e;
        csw_pkg::entry_t kept[$];
        step_responses.delete();
        case (r.mode)
            csw_pkg::MODE_WAIT:
            begin
                if (sem_count > 0)
                begin
                    sem_count = sem_count - 16'sd1;
                    note(csw_pkg::KIND_GRANTED, r.thread, 8'sd0, 1'b1);
                end
                else if (waiters.size() >= DEPTH)
                begin
                    // refused: count untouched
                    note(csw_pkg::KIND_Q_FULL, r.thread, 8'sd0, 1'b1);
                end
                else
                begin
                    sem_count = clamp_count(sem_count, -1);
                    e.thread    = r.thread;
                    e.ticks     = r.max_wait;
                    e.unlimited = (r.max_wait == 16'd0);
                    waiters.push_back(e);
                    note(csw_pkg::KIND_BLOCKED, r.thread, 8'sd0, 1'b1);
                end
            end
            csw_pkg::MODE_SIGNAL:
            begin
                if (r.sig < 0)
                    note(csw_pkg::KIND_SIG_ERR, 8'd0, r.sig, 1'b1);
                else if (r.sig == 0)
                begin
                    // increment first; the release shows the new count
                    was_neg   = (sem_count < 0);
                    sem_count = clamp_count(sem_count, 1);
                    if (was_neg && waiters.size() > 0)
                    begin
                        e = waiters.pop_front();
                        note(csw_pkg::KIND_REL_SIG, e.thread, 8'sd0, 1'b0);
                    end
                    note(csw_pkg::KIND_SIG_DONE, 8'd0, 8'sd0, 1'b1);
                end
                else
                begin
                    // releases show the count before the addition
                    freed = 0;
                    while (waiters.size() > 0 && freed < int'(r.sig))
                    begin
                        e = waiters.pop_front();
                        note(csw_pkg::KIND_REL_SIG, e.thread, 8'sd0, 1'b0);
                        freed++;
                    end
                    sem_count = clamp_count(sem_count, int'(r.sig));
                    note(csw_pkg::KIND_SIG_DONE, 8'd0, 8'(freed), 1'b1);
                end
            end
            csw_pkg::MODE_TICK:
            begin
                // count down limited waiters, release the expired in queue order
                foreach (waiters[i])
                begin
                    e = waiters[i];
                    if (!e.unlimited && e.ticks > 16'd0)
                        e.ticks = e.ticks - 16'd1;
                    if (!e.unlimited && e.ticks == 16'd0)
                    begin
                        sem_count = clamp_count(sem_count, 1);
                        note(csw_pkg::KIND_REL_TMO, e.thread, 8'sd0, 1'b0);
                    end
                    else
                        kept.push_back(e);
                end
                waiters = kept;
                note(csw_pkg::KIND_TICK_DONE, 8'd0, 8'sd0, 1'b1);
            end
            default:
                note(csw_pkg::KIND_TICK_DONE, 8'd0, 8'sd0, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    function automatic void add_row(logic [1:0] m, logic [7:0] t, logic [15:0] w,
                                    logic signed [7:0] s);
        plan_row_t row;
        row = '{cfg: 1'b0, cfg_val: 15'd0, req: '{m, t, w, s}, typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void add_typed(logic [1:0] m, logic [7:0] t, logic [15:0] w,
                                      logic signed [7:0] s, logic [2:0] k,
                                      logic [7:0] rt, logic signed [7:0] tot,
                                      logic signed [15:0] cnt);
        plan_row_t row;
        row = '{cfg: 1'b0, cfg_val: 15'd0, req: '{m, t, w, s}, typed: 1'b1,
                want: '{k, rt, tot, cnt, 1'b1}};
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(logic [14:0] v);
        plan_row_t row;
        row = '{cfg: 1'b1, cfg_val: v, req: '0, typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void build_plan();
        logic [15:0] mw;
        // straight after reset the count is 0 and the queue is empty
        add_typed(csw_pkg::MODE_SIGNAL, 8'h00, 16'h0000, 8'sh80,
                  csw_pkg::KIND_SIG_ERR, 8'h00, 8'sh80, 16'sd0);
        add_typed(MODE_SPARE, 8'hFF, 16'hFFFF, 8'sh7F,
                  csw_pkg::KIND_TICK_DONE, 8'h00, 8'sd0, 16'sd0);
        add_typed(csw_pkg::MODE_SIGNAL, 8'h00, 16'h0000, 8'sd0,
                  csw_pkg::KIND_SIG_DONE, 8'h00, 8'sd0, 16'sd1);
        add_typed(csw_pkg::MODE_WAIT, 8'hFF, 16'hFFFF, 8'sd0,
                  csw_pkg::KIND_GRANTED, 8'hFF, 8'sd0, 16'sd0);
        // top of the register range, then a signal that saturates the count
        add_cfg(15'h7FFF);
        add_typed(csw_pkg::MODE_SIGNAL, 8'h00, 16'h0000, 8'sh7F,
                  csw_pkg::KIND_SIG_DONE, 8'h00, 8'sd0, 16'sh7FFF);
        // fill the queue with a mix of short, unlimited and long timeouts
        add_cfg(15'h0000);
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i % 4)
                0:       mw = 16'd1;
                1:       mw = 16'd0;
                2:       mw = 16'd2;
                default: mw = 16'hFFFF;
            endcase
            add_row(csw_pkg::MODE_WAIT, 8'(8'h10 + i), mw, 8'sd0);
        end
        add_typed(csw_pkg::MODE_WAIT, 8'hEE, 16'h0003, 8'sd0,
                  csw_pkg::KIND_Q_FULL, 8'hEE, 8'sd0, -16'sd16);
        add_row(csw_pkg::MODE_TICK, 8'h00, 16'h0000, 8'sd0);     // expires the one-tick waiters
        add_row(csw_pkg::MODE_SIGNAL, 8'h00, 16'h0000, 8'sd0);   // zero signal with waiters
        add_row(csw_pkg::MODE_SIGNAL, 8'h00, 16'h0000, 8'sd3);
        add_row(csw_pkg::MODE_SIGNAL, 8'h00, 16'h0000, 8'sh7F);  // frees all that remain
    endfunction

    // Random request, weighted toward waits that fill the queue and
    // short timeouts that a few ticks will expire.
    function automatic sem_req_t random_request(int wait_pct);
        sem_req_t r;
        int       sel;
        r.mode     = 2'($urandom);
        r.thread   = 8'($urandom);
        r.max_wait = 16'($urandom);
        r.sig      = 8'($urandom);
        if ($urandom_range(0, 99) < wait_pct)
        begin
            r.mode = csw_pkg::MODE_WAIT;
            sel = $urandom_range(0, 9);
            if (sel < 3)
                r.max_wait = 16'd0;
            else if (sel < 7)
                r.max_wait = 16'($urandom_range(1, 4));
            else if (sel == 7)
                r.max_wait = 16'hFFFF;
        end
        else
        begin
            sel = $urandom_range(0, 19);
            if (sel < 9)
            begin
                r.mode = csw_pkg::MODE_SIGNAL;
                sel = $urandom_range(0, 9);
                if (sel < 4)
                    r.sig = 8'sd0;
                else if (sel < 8)
                    r.sig = 8'($urandom_range(1, 6));
                else if (sel == 8)
                    r.sig = 8'($urandom_range(7, 127));
                else
                    r.sig = 8'(-int'($urandom_range(1, 128)));
            end
            else if (sel < 19)
                r.mode = csw_pkg::MODE_TICK;
            else
                r.mode = MODE_SPARE;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Present one request, hold it until taken, then queue its responses.
    task automatic send_request(input sem_req_t r, input bit typed, input sem_rsp_t want);
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= r.mode;
        req_ch.thread_id    <= r.thread;
        req_ch.max_wait     <= r.max_wait;
        req_ch.signal_count <= r.sig;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // taken at this edge; keep the predictor in step even for typed rows
        semaphore_step(r);
        if (typed)
            due_responses.push_back(want);
        else
            foreach (step_responses[i])
                due_responses.push_back(step_responses[i]);
        if (src_odds != 0 && $urandom_range(0, src_odds - 1) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(posedge clk);
        end
    endtask

    // Hold off until every outstanding response has been seen.
    // With nothing outstanding the sender is already idle.
    task automatic drain();
        if (due_responses.size() != 0)
        begin
            req_ch.valid <= 1'b0;
            while (due_responses.size() != 0)
                @(posedge clk);
        end
    endtask

    // Register write with the block idle; it reloads the count only.
    task automatic load_initial(input logic [14:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sem_count = {1'b0, v};
    endtask

    // ------------------------------------------------------------------
    // Response side: check against the oldest expectation, drive stalls
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : rsp_monitor
        sem_rsp_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (due_responses.size() == 0)
                begin
                    $error("response with no request outstanding: kind %0d", rsp_ch.kind);
                    errors++;
                end
                else
                begin
                    want = due_responses.pop_front();
                    check_field("kind", want.kind, rsp_ch.kind);
                    check_field("released_thread", want.thread, rsp_ch.released_thread);
                    check_field("released_total", int'($signed(want.total)),
                                int'($signed(rsp_ch.released_total)));
                    check_field("count_now", int'($signed(want.count)),
                                int'($signed(rsp_ch.count_now)));
                    check_field("last", want.last, rsp_ch.last);
                end
            end
            // receiver stalls come in bursts; stall_left counts down the rest of each burst
            if (sink_odds == 0)
            begin
                stall_left = 0;
                rsp_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, sink_odds - 1) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
        else
            rsp_ch.ready <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [14:0] cfg;
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= 15'd0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= csw_pkg::MODE_WAIT;
        req_ch.thread_id    <= 8'd0;
        req_ch.max_wait     <= 16'd0;
        req_ch.signal_count <= 8'sd0;
        sem_count = 16'sd0;     // register resets to 0
        build_plan();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].cfg)
                load_initial(plan[i].cfg_val);
            else
                send_request(plan[i].req, plan[i].typed, plan[i].want);
        end

        // random phases; each starts from a fresh initial count with the
        // queue carried over, the last one without any idling
        for (int p = 0; p < PHASES; p++)
        begin
            src_odds  = phase_src_odds[p];
            sink_odds = phase_sink_odds[p];
            cfg = (p == 5) ? 15'($urandom_range(0, 32767)) : phase_cfg[p];
            load_initial(cfg);
            repeat (ITEMS_PER_PHASE)
            begin
                // now and then let everything settle before the next request
                if (src_odds != 0 && $urandom_range(0, 49) == 0)
                    drain();
                send_request(random_request(phase_wait_pct[p]), 1'b0, '0);
            end
        end

        drain();
        repeat (SETTLE)
            @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/csw_pkg.sv
rtl/csw_if.sv
rtl/csw_cell.sv
rtl/csw_queue.sv
rtl/counting_semaphore_timed_waiters.sv
verif/tb_counting_semaphore_timed_waiters.sv
